### rtl/vtrp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtrp_pkg: shared definitions of the virtual-time rate pacer
// Widths, constants, register indexes and the command and status bundles
// that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package vtrp_pkg;

	// Field widths.
	localparam int BYTES_W = 16;
	localparam int TIME_W  = 64;
	localparam int RATE_W  = 17;
	localparam int BURST_W = 32;

	// Configuration port.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_RATE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BURST = 1'd1;

	// Burst window used when the register holds zero (10 ms).
	localparam logic [BURST_W-1:0] DEFAULT_BURST_NS = 32'd10_000_000;

	// Cost of one byte at 1 Mbit/s in ns, and the width of the dividend.
	localparam int NSPB_W = 13;
	localparam logic [NSPB_W-1:0] NS_PER_BYTE_MBPS = 13'd8000;
	localparam int DIVD_W = BYTES_W + NSPB_W;
	localparam int CNT_W  = $clog2(DIVD_W);

	// Controller to datapath commands.
	typedef struct packed {
		logic capture;
		logic calc_low;
		logic calc_start;
		logic div_step;
		logic commit;
	} vtrp_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic rate_zero;
		logic div_last;
		logic out_free;
	} vtrp_sts_t;

endpackage

### rtl/vtrp_pkt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtrp_pkt_if: packet request channel
// Carries a packet length and the current time from the sender to the pacer.
// ----------------------------------------------------------------------------
interface vtrp_pkt_if import vtrp_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [BYTES_W-1:0] packet_bytes;
	logic [TIME_W-1:0]  now_ns;

	modport source (output valid, output packet_bytes, output now_ns, input ready);
	modport sink (input valid, input packet_bytes, input now_ns, output ready);
endinterface

### rtl/vtrp_wait_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtrp_wait_if: pacing decision channel
// Carries the wait time of each packet from the pacer to the receiver.
// ----------------------------------------------------------------------------
interface vtrp_wait_if import vtrp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [TIME_W-1:0] wait_ns;

	modport source (output valid, output wait_ns, input ready);
	modport sink (input valid, input wait_ns, output ready);
endinterface

### rtl/virtual_time_rate_pacer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// virtual_time_rate_pacer_top: virtual-time packet pacer
// For each packet it returns how long to wait before sending it, based on a
// virtual next-send time, the shaping rate and a burst credit window.
// ----------------------------------------------------------------------------
// Usage:
//   pkt carries packet_bytes and now_ns; sched returns wait_ns, one result
//   per packet, in order. Both use valid/ready; a transfer happens when both
//   are high at a rising clock edge.
//   cfg_we/cfg_index/cfg_data write the shaping rate (index 0, Mbit/s, zero
//   turns shaping off) and burst_window_ns (index 1, zero means 10 ms). Write
//   them only while no packet is in flight.
//   The result is registered; when shaping is off the cost division is
//   skipped. Otherwise it runs one quotient bit per cycle over 29 bits, and
//   pkt.ready is high only while the sequencer is idle, so a packet holds
//   the block until its result is committed.
//   The result sits in an output register, so the next packet is taken while
//   a stalled receiver still holds the previous result; the following commit
//   waits until that register is free.
//   Reset clears the configuration registers, the output valid flag and the
//   next-send time to zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
module virtual_time_rate_pacer_top import vtrp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	vtrp_pkt_if.sink              pkt,
	vtrp_wait_if.source           sched,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	vtrp_cmd_t cmd;
	vtrp_sts_t sts;

	// Sequencer.
	vtrp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_valid (pkt.valid),
		.pkt_ready (pkt.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath.
	vtrp_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.packet_bytes (pkt.packet_bytes),
		.now_ns       (pkt.now_ns),
		.out_ready    (sched.ready),
		.out_valid    (sched.valid),
		.wait_ns      (sched.wait_ns),
		.cmd          (cmd),
		.sts          (sts)
	);

endmodule

### rtl/vtrp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtrp_ctrl: pacer sequencer
// Steps one packet through window floor, start time, the bit-serial cost
// division (skipped with shaping off) and the commit to the output register.
// ----------------------------------------------------------------------------
module vtrp_ctrl import vtrp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      pkt_valid,
	output logic      pkt_ready,
	input  vtrp_sts_t sts,
	output vtrp_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LOW   = 3'd1;
	localparam logic [2:0] ST_START = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign pkt_ready = (state_q == ST_IDLE);

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (pkt_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_LOW;
				end
			end
			ST_LOW: begin
				cmd.calc_low = 1'b1;
				state_d      = ST_START;
			end
			ST_START: begin
				cmd.calc_start = 1'b1;
				// Shaping off: no cost to work out.
				state_d = sts.rate_zero ? ST_DONE : ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// A result is only committed when the output register can take it.
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> sts.out_free)
		else $error("commit while output register is occupied");

	// A transfer on the request channel always starts a new packet.
	a_accept_low: assert property (@(posedge clk) disable iff (!arst_n)
		(pkt_valid && pkt_ready) |=> (state_q == ST_LOW))
		else $error("accepted packet did not start processing");

	// After a commit the sequencer is ready for the next packet.
	a_commit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> pkt_ready)
		else $error("not ready after commit");

endmodule

### rtl/vtrp_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtrp_dp: pacer datapath
// Holds the configuration registers and the virtual next-send time, works out
// start and wait times, divides the packet cost one bit per cycle and keeps
// the output register.
// ----------------------------------------------------------------------------
module vtrp_dp import vtrp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [BYTES_W-1:0]    packet_bytes,
	input  logic [TIME_W-1:0]     now_ns,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [TIME_W-1:0]     wait_ns,
	input  vtrp_cmd_t             cmd,
	output vtrp_sts_t             sts
);

	logic [RATE_W-1:0]  rate_q;
	logic [BURST_W-1:0] burst_q;
	logic [TIME_W-1:0]  nst_q;
	logic [BYTES_W-1:0] bytes_q;
	logic [TIME_W-1:0]  now_q;
	logic [TIME_W-1:0]  lo_q;
	logic [DIVD_W-1:0]  prod_q;
	logic [TIME_W-1:0]  start_q;
	logic [TIME_W-1:0]  wait_q;
	logic [DIVD_W-1:0]  div_q;
	logic [RATE_W-1:0]  rem_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               out_valid_q;
	logic [TIME_W-1:0]  out_wait_q;

	logic [BURST_W-1:0] window;
	logic [TIME_W:0]    lo_diff;
	logic [RATE_W:0]    trial;
	logic [RATE_W:0]    trial_sub;
	logic               quo_bit;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q  <= '0;
			burst_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RATE:  rate_q  <= cfg_data[RATE_W-1:0];
				REG_BURST: burst_q <= cfg_data[BURST_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Window floor: now minus the window, or zero when now lies inside it.
	assign window  = (burst_q == '0) ? DEFAULT_BURST_NS : burst_q;
	assign lo_diff = {1'b0, now_q} - {1'b0, (TIME_W - BURST_W)'(0), window};

	// One restoring division step on the packet cost.
	assign trial     = {rem_q, div_q[DIVD_W-1]};
	assign trial_sub = trial - {1'b0, rate_q};
	assign quo_bit   = !trial_sub[RATE_W];

	// Packet capture and the start, wait and division registers.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			bytes_q <= packet_bytes;
			now_q   <= now_ns;
		end
		if (cmd.calc_low) begin
			lo_q   <= (lo_diff[TIME_W] || lo_diff[TIME_W-1:0] == '0) ? '0 :
			          lo_diff[TIME_W-1:0];
			prod_q <= DIVD_W'(bytes_q) * DIVD_W'(NS_PER_BYTE_MBPS);
		end
		if (cmd.calc_start) begin
			start_q <= (nst_q > lo_q) ? nst_q : lo_q;
			div_q   <= prod_q;
			rem_q   <= '0;
			cnt_q   <= CNT_W'(DIVD_W - 1);
		end
		if (cmd.div_step) begin
			div_q  <= {div_q[DIVD_W-2:0], quo_bit};
			rem_q  <= quo_bit ? trial_sub[RATE_W-1:0] : trial[RATE_W-1:0];
			cnt_q  <= cnt_q - CNT_W'(1);
			wait_q <= (start_q > now_q) ? start_q - now_q : '0;
		end
	end

	// Virtual next-send time, advanced by the cost when shaping is on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nst_q <= '0;
		end else if (cmd.commit && rate_q != '0) begin
			nst_q <= start_q + TIME_W'(div_q);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_wait_q <= (rate_q == '0) ? '0 : wait_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign wait_ns       = out_wait_q;
	assign sts.rate_zero = (rate_q == '0);
	assign sts.div_last  = (cnt_q == '0);
	assign sts.out_free  = !out_valid_q || out_ready;

	// A commit always leaves a result in the output register.
	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("commit did not load the output register");

	// The next-send time moves only on a commit with shaping on.
	a_nst_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.commit && rate_q != '0) |=> $stable(nst_q))
		else $error("next-send time changed outside a commit");

	// Each division step counts down by one.
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_step && !sts.div_last) |=> (cnt_q == $past(cnt_q) - CNT_W'(1)))
		else $error("division counter skipped");

endmodule
